// ===== rtl/nearest_point_search_unit_macros.svh =====
// Assertion helpers shared by the search unit modules.
`ifndef NEAREST_POINT_SEARCH_UNIT_MACROS_SVH
`define NEAREST_POINT_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication.
`define NPSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NPSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/npsu_pkg.sv =====
package npsu_pkg;

   localparam int unsigned MAX_POINTS_DEF  = 256;
   localparam int unsigned ROUTE_SLOTS_DEF = 4;

   localparam int unsigned LAT_W      = 28;
   localparam int unsigned LNG_W      = 29;
   localparam int unsigned ID_W       = 21;
   localparam int unsigned PT_W       = LAT_W + LNG_W + ID_W;
   localparam int unsigned OUT_IDX_W  = 8;
   localparam int unsigned DLAT_W     = LAT_W + 1;
   localparam int unsigned DLNG_W     = LNG_W + 1;
   localparam int unsigned SQLAT_W    = 57;
   localparam int unsigned SQLNG_W    = 59;
   localparam int unsigned DIST_W     = 59;
   localparam int unsigned DIST_OUT_W = 58;

   typedef enum logic [1:0] {
      REQ_CLEAR   = 2'd0,
      REQ_APPEND  = 2'd1,
      REQ_NEAREST = 2'd2,
      REQ_PAIR    = 2'd3
   } npsu_req_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FEW  = 2'd1,
      STAT_FULL = 2'd2
   } npsu_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ROW,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } npsu_state_type;

   typedef struct packed {
      logic            accept;
      logic            clear;
      logic            append;
      logic            scan_start;
      logic            rd_en;
      logic            tag_valid;
      logic            ref_load;
      logic            out_load;
      logic            res_blank;
      npsu_status_type res_status;
   } npsu_cmd_type;

   typedef struct packed {
      npsu_req_type req_kind;
      logic         pipe_busy;
      logic         out_busy;
   } npsu_stat_type;

   // Wrap a two-bit slot number into the configured slot range.
   function automatic logic [1:0] slot_wrap(input logic [1:0] v, input int unsigned slots);
      int unsigned r;
      r = int'(v);
      for (int k = 0; k < 3; k++) begin
         if (r >= slots) begin
            r = r - slots;
         end
      end
      return r[1:0];
   endfunction

endpackage

// ===== rtl/npsu_ram.sv =====
module npsu_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_array[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/npsu_ctrl.sv =====
`include "nearest_point_search_unit_macros.svh"

module npsu_ctrl #(
   parameter int unsigned MAX_POINTS = npsu_pkg::MAX_POINTS_DEF,
   localparam int unsigned IDX_W = $clog2(MAX_POINTS),
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  npsu_pkg::npsu_stat_type stat,
   input  logic [CNT_W-1:0]       count,
   output npsu_pkg::npsu_cmd_type  cmd,
   output logic [IDX_W-1:0]       rd_idx
);
   import npsu_pkg::*;

   npsu_state_type  state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   npsu_status_type status_ff, status_in;
   logic            blank_ff, blank_in;

   logic pair;
   logic last_j;
   logic last_i;

   assign pair   = (stat.req_kind == REQ_PAIR);
   assign last_j = (CNT_W'(j_ff) == (count - CNT_W'(1)));
   assign last_i = (CNT_W'(i_ff) == (count - CNT_W'(1)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (stat.req_kind)
               REQ_NEAREST: state_in = (count == '0) ? ST_DONE : ST_SCAN;
               REQ_PAIR:    state_in = (count < CNT_W'(2)) ? ST_DONE : ST_ROW;
               default:     state_in = ST_DONE;
            endcase
         end
         ST_ROW: state_in = ST_SCAN;
         ST_SCAN: begin
            if (last_j) begin
               state_in = (pair && !last_i) ? ST_ROW : ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      status_in = status_ff;
      blank_in  = blank_ff;
      case (state_ff)
         ST_DECIDE: begin
            i_in      = '0;
            j_in      = '0;
            status_in = STAT_OK;
            blank_in  = 1'b1;
            case (stat.req_kind)
               REQ_APPEND: begin
                  if (count >= CNT_W'(MAX_POINTS)) begin
                     status_in = STAT_FULL;
                  end else begin
                     blank_in = 1'b0;
                  end
               end
               REQ_NEAREST: begin
                  if (count == '0) begin
                     status_in = STAT_FEW;
                  end else begin
                     blank_in = 1'b0;
                  end
               end
               REQ_PAIR: begin
                  if (count < CNT_W'(2)) begin
                     status_in = STAT_FEW;
                  end else begin
                     blank_in = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN: begin
            if (last_j) begin
               j_in = '0;
               i_in = i_ff + IDX_W'(1);
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.res_blank  = blank_ff;
      cmd.res_status = status_ff;
      rd_idx         = j_ff;
      req_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_DECIDE: begin
            cmd.clear      = (stat.req_kind == REQ_CLEAR);
            cmd.append     = (stat.req_kind == REQ_APPEND) && (count < CNT_W'(MAX_POINTS));
            cmd.scan_start = 1'b1;
         end
         ST_ROW: begin
            rd_idx       = i_ff;
            cmd.rd_en    = 1'b1;
            cmd.ref_load = 1'b1;
         end
         ST_SCAN: begin
            cmd.rd_en     = 1'b1;
            cmd.tag_valid = !pair || (j_ff != i_ff);
         end
         ST_DONE: begin
            cmd.out_load = !stat.out_busy;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         i_ff      <= '0;
         j_ff      <= '0;
         status_ff <= STAT_OK;
         blank_ff  <= 1'b1;
      end else begin
         state_ff  <= state_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         status_ff <= status_in;
         blank_ff  <= blank_in;
      end
   end

   `NPSU_ASSERT_NOW(a_scan_in_table, clock, reset, (state_ff == ST_SCAN), (CNT_W'(j_ff) < count), "scan index past table count")
   `NPSU_ASSERT_NEXT(a_accept_decide, clock, reset, (req_valid && req_ready), (state_ff == ST_DECIDE), "accepted beat did not reach decode")
   `NPSU_ASSERT_NEXT(a_row_restart, clock, reset, (state_ff == ST_ROW), ((state_ff == ST_SCAN) && (j_ff == '0)), "row load did not restart inner scan")

endmodule

// ===== rtl/npsu_dp.sv =====
`include "nearest_point_search_unit_macros.svh"

module npsu_dp #(
   parameter int unsigned MAX_POINTS  = npsu_pkg::MAX_POINTS_DEF,
   parameter int unsigned ROUTE_SLOTS = npsu_pkg::ROUTE_SLOTS_DEF,
   localparam int unsigned IDX_W  = $clog2(MAX_POINTS),
   localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_type,
   input  logic [1:0]                   req_route_slot,
   input  logic signed [npsu_pkg::LAT_W-1:0] req_latitude,
   input  logic signed [npsu_pkg::LNG_W-1:0] req_longitude,
   input  logic signed [npsu_pkg::ID_W-1:0]  req_point_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [npsu_pkg::OUT_IDX_W-1:0] rsp_first_index,
   output logic [npsu_pkg::OUT_IDX_W-1:0] rsp_second_index,
   output logic signed [npsu_pkg::ID_W-1:0] rsp_first_id,
   output logic signed [npsu_pkg::ID_W-1:0] rsp_second_id,
   output logic [npsu_pkg::DIST_OUT_W-1:0] rsp_best_sq_distance,
   input  npsu_pkg::npsu_cmd_type        cmd,
   input  logic [IDX_W-1:0]             rd_idx,
   output npsu_pkg::npsu_stat_type       stat,
   output logic [CNT_W-1:0]             count
);
   import npsu_pkg::*;

   localparam int unsigned SLOT_W = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
   localparam int unsigned DEPTH  = ROUTE_SLOTS * MAX_POINTS;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // request context
   npsu_req_type       kind_ff;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [ADDR_W-1:0]  base_ff;
   logic [ID_W-1:0]    qid_ff;
   logic [LAT_W-1:0]   ref_lat_ff;
   logic [LNG_W-1:0]   ref_lng_ff;
   logic [ID_W-1:0]    ref_id_ff;
   logic [IDX_W-1:0]   ref_idx_ff;
   logic               ref_pend_ff;
   logic [IDX_W-1:0]   ref_pend_idx_ff;

   logic [CNT_W-1:0]   count_ff [ROUTE_SLOTS];

   // point memory
   logic [ADDR_W-1:0]  wr_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [PT_W-1:0]    wr_data;
   logic [PT_W-1:0]    rd_data;
   logic [LAT_W-1:0]   d_lat;
   logic [LNG_W-1:0]   d_lng;
   logic [ID_W-1:0]    d_id;

   // distance pipeline
   logic               v0_ff, v1_ff, v2_ff;
   logic [IDX_W-1:0]   idx0_ff;
   logic signed [DLAT_W-1:0] dlat1_ff;
   logic signed [DLNG_W-1:0] dlng1_ff;
   logic [IDX_W-1:0]   a_idx1_ff, b_idx1_ff, a_idx2_ff, b_idx2_ff;
   logic [ID_W-1:0]    a_id1_ff, b_id1_ff, a_id2_ff, b_id2_ff;
   logic signed [2*DLAT_W-1:0] p_lat;
   logic signed [2*DLNG_W-1:0] p_lng;
   logic [SQLAT_W-1:0] sqlat2_ff;
   logic [SQLNG_W-1:0] sqlng2_ff;
   logic [DIST_W-1:0]  sum;
   logic               take;

   // running best
   logic               have_ff;
   logic [DIST_W-1:0]  best_dist_ff;
   logic [IDX_W-1:0]   best_a_idx_ff, best_b_idx_ff;
   logic [ID_W-1:0]    best_a_id_ff, best_b_id_ff;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [OUT_IDX_W-1:0]  rsp_first_index_ff, rsp_second_index_ff;
   logic [ID_W-1:0]       rsp_first_id_ff, rsp_second_id_ff;
   logic [DIST_OUT_W-1:0] rsp_dist_ff;
   logic [IDX_W+OUT_IDX_W-1:0] first_wide, second_wide;
   logic                  pair;
   logic [DIST_OUT_W-1:0] dist_sat;

   assign slot_in = SLOT_W'(slot_wrap(req_route_slot, ROUTE_SLOTS));
   assign count   = count_ff[slot_ff];

   assign wr_addr = base_ff + ADDR_W'(count[IDX_W-1:0]);
   assign rd_addr = base_ff + ADDR_W'(rd_idx);
   assign wr_data = {ref_lat_ff, ref_lng_ff, qid_ff};
   assign d_lat   = rd_data[PT_W-1 -: LAT_W];
   assign d_lng   = rd_data[ID_W +: LNG_W];
   assign d_id    = rd_data[ID_W-1:0];

   npsu_ram #(
      .WIDTH (PT_W),
      .DEPTH (DEPTH)
   ) u_points (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (cmd.accept) begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff    <= npsu_req_type'(req_type);
         base_ff    <= ADDR_W'(slot_in) * ADDR_W'(MAX_POINTS);
         qid_ff     <= req_point_id;
         ref_lat_ff <= req_latitude;
         ref_lng_ff <= req_longitude;
      end else if (ref_pend_ff) begin
         // row point of a pair scan arrives from memory
         ref_lat_ff <= d_lat;
         ref_lng_ff <= d_lng;
      end
      if (ref_pend_ff) begin
         ref_id_ff  <= d_id;
         ref_idx_ff <= ref_pend_idx_ff;
      end
      ref_pend_idx_ff <= rd_idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < ROUTE_SLOTS; s++) begin
            count_ff[s] <= '0;
         end
      end else if (cmd.clear) begin
         count_ff[slot_ff] <= '0;
      end else if (cmd.append) begin
         count_ff[slot_ff] <= count_ff[slot_ff] + CNT_W'(1);
      end
   end

   assign p_lat = dlat1_ff * dlat1_ff;
   assign p_lng = dlng1_ff * dlng1_ff;
   assign sum   = {{(DIST_W-SQLAT_W){1'b0}}, sqlat2_ff} + sqlng2_ff;
   assign take  = v2_ff && (!have_ff || (sum < best_dist_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         ref_pend_ff <= 1'b0;
         have_ff     <= 1'b0;
      end else begin
         v0_ff       <= cmd.rd_en && cmd.tag_valid;
         v1_ff       <= v0_ff;
         v2_ff       <= v1_ff;
         ref_pend_ff <= cmd.ref_load;
         if (cmd.scan_start) begin
            have_ff <= 1'b0;
         end else if (take) begin
            have_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx0_ff   <= rd_idx;
      dlat1_ff  <= {ref_lat_ff[LAT_W-1], ref_lat_ff} - {d_lat[LAT_W-1], d_lat};
      dlng1_ff  <= {ref_lng_ff[LNG_W-1], ref_lng_ff} - {d_lng[LNG_W-1], d_lng};
      a_idx1_ff <= ref_idx_ff;
      a_id1_ff  <= ref_id_ff;
      b_idx1_ff <= idx0_ff;
      b_id1_ff  <= d_id;
      sqlat2_ff <= p_lat[SQLAT_W-1:0];
      sqlng2_ff <= p_lng[SQLNG_W-1:0];
      a_idx2_ff <= a_idx1_ff;
      a_id2_ff  <= a_id1_ff;
      b_idx2_ff <= b_idx1_ff;
      b_id2_ff  <= b_id1_ff;
      if (cmd.append) begin
         // append reports its slot index and id through the best registers
         best_dist_ff  <= '0;
         best_b_idx_ff <= count[IDX_W-1:0];
         best_b_id_ff  <= qid_ff;
      end else if (take) begin
         best_dist_ff  <= sum;
         best_a_idx_ff <= a_idx2_ff;
         best_a_id_ff  <= a_id2_ff;
         best_b_idx_ff <= b_idx2_ff;
         best_b_id_ff  <= b_id2_ff;
      end
   end

   assign pair        = (kind_ff == REQ_PAIR);
   assign first_wide  = {{OUT_IDX_W{1'b0}}, (pair ? best_a_idx_ff : best_b_idx_ff)};
   assign second_wide = {{OUT_IDX_W{1'b0}}, best_b_idx_ff};
   assign dist_sat    = best_dist_ff[DIST_W-1] ? {DIST_OUT_W{1'b1}}
                                               : best_dist_ff[DIST_OUT_W-1:0];

   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.res_status;
         if (cmd.res_blank) begin
            rsp_first_index_ff  <= '0;
            rsp_second_index_ff <= '0;
            rsp_first_id_ff     <= '0;
            rsp_second_id_ff    <= '0;
            rsp_dist_ff         <= '0;
         end else begin
            rsp_first_index_ff  <= first_wide[OUT_IDX_W-1:0];
            rsp_second_index_ff <= pair ? second_wide[OUT_IDX_W-1:0] : '0;
            rsp_first_id_ff     <= pair ? best_a_id_ff : best_b_id_ff;
            rsp_second_id_ff    <= pair ? best_b_id_ff : '0;
            rsp_dist_ff         <= dist_sat;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_first_index      = rsp_first_index_ff;
   assign rsp_second_index     = rsp_second_index_ff;
   assign rsp_first_id         = rsp_first_id_ff;
   assign rsp_second_id        = rsp_second_id_ff;
   assign rsp_best_sq_distance = rsp_dist_ff;

   assign stat.req_kind  = kind_ff;
   assign stat.pipe_busy = v0_ff || v1_ff || v2_ff;
   assign stat.out_busy  = rsp_valid_ff && !rsp_ready;

   `NPSU_ASSERT_NEXT(a_rsp_only_on_load, clock, reset, (!rsp_valid_ff && !cmd.out_load), !rsp_valid_ff, "result beat appeared without a load")
   `NPSU_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, (count <= CNT_W'(MAX_POINTS)), "table count above capacity")
   `NPSU_ASSERT_NEXT(a_rsp_hold, clock, reset, (rsp_valid_ff && !rsp_ready), rsp_valid_ff, "stalled result beat dropped")

endmodule

// ===== rtl/nearest_point_search_unit.sv =====
// Brute-force nearest point search over per-route point tables.
// Request channel (req_*): one beat is one command on table req_route_slot:
//   clear, append a point (latitude, longitude, id), nearest to a query
//   position, or closest pair of stored points. Response channel (rsp_*):
//   exactly one beat per request, in request order.
// One request is in flight at a time. Memory reads per request:
//   clear / append / too-few-points: none
//   nearest query on n points: one memory read per point
//   closest pair on n points: one row fetch, then n reads per row through
//   the single read port of the point memory
// Distances go through a three-stage subtract / square / compare pipeline.
// A finished result sits in an output register; the next request is taken as
// soon as the result is loaded there, and a stalled response only holds back
// the loading of the following result.
// Reset clears all table counts and both handshakes; point memory needs no
// clearing pass because entries beyond a table count are never read.
module nearest_point_search_unit #(
   parameter int unsigned MAX_POINTS  = npsu_pkg::MAX_POINTS_DEF,
   parameter int unsigned ROUTE_SLOTS = npsu_pkg::ROUTE_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [1:0]                      req_route_slot,
   input  logic signed [npsu_pkg::LAT_W-1:0] req_latitude,
   input  logic signed [npsu_pkg::LNG_W-1:0] req_longitude,
   input  logic signed [npsu_pkg::ID_W-1:0]  req_point_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [npsu_pkg::OUT_IDX_W-1:0]  rsp_first_index,
   output logic [npsu_pkg::OUT_IDX_W-1:0]  rsp_second_index,
   output logic signed [npsu_pkg::ID_W-1:0]  rsp_first_id,
   output logic signed [npsu_pkg::ID_W-1:0]  rsp_second_id,
   output logic [npsu_pkg::DIST_OUT_W-1:0] rsp_best_sq_distance
);
   import npsu_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_POINTS);
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

   npsu_cmd_type     cmd;
   npsu_stat_type    stat;
   logic [IDX_W-1:0] rd_idx;
   logic [CNT_W-1:0] count;

   npsu_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .count     (count),
      .cmd       (cmd),
      .rd_idx    (rd_idx)
   );

   npsu_dp #(
      .MAX_POINTS  (MAX_POINTS),
      .ROUTE_SLOTS (ROUTE_SLOTS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .req_type             (req_type),
      .req_route_slot       (req_route_slot),
      .req_latitude         (req_latitude),
      .req_longitude        (req_longitude),
      .req_point_id         (req_point_id),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_first_index      (rsp_first_index),
      .rsp_second_index     (rsp_second_index),
      .rsp_first_id         (rsp_first_id),
      .rsp_second_id        (rsp_second_id),
      .rsp_best_sq_distance (rsp_best_sq_distance),
      .cmd                  (cmd),
      .rd_idx               (rd_idx),
      .stat                 (stat),
      .count                (count)
   );

endmodule
